[hdl/deq_pkg.sv]
// Shared types and constants for the deadline event queue.
package deq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DL_W        = 50;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NFIRE_W     = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        REQ_SCHEDULE = 2'd0,
        REQ_FIRE     = 2'd1,
        REQ_CLEAR    = 2'd2,
        REQ_UNUSED   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_SCHEDULED = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_FIRED     = 3'd2,
        ST_NONE_DUE  = 3'd3,
        ST_CLEARED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic signed [DL_W-1:0] deadline;
        logic [7:0]             listener;
        logic [31:0]            cookie;
    } t_entry;

    typedef struct packed {
        t_cell_op               op;
        logic signed [DL_W-1:0] key;
        t_entry                 new_entry;
    } t_cell_ctl;

endpackage

[hdl/deq_cell.sv]
// One queue slot: holds an entry, shifts right on insert and left on pop.
module deq_cell
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  logic      i_prev_keep,
    input  t_entry    i_left,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_keep  = i_occ && (r_entry.deadline <= i_ctl.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INSERT: begin
                if (!o_keep) begin
                    n_entry = i_prev_keep ? i_ctl.new_entry : i_left;
                end
            end
            OP_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[hdl/deadline_event_queue.sv]
// Top level: sequencer, result register and the sorted chain of queue cells.
// Schedule, clear: the sequencer state is registered first, then the result register.
// Fire: one entry leaves the head cell per cycle while the output is not stalled.
// One item at a time: a new request is accepted only while the sequencer is idle.
// Output stalls hold the sequencer; the result register decouples the output.
// Reset clears the entry count, sequencer and valid flags; cell contents need none.
module deadline_event_queue
    import deq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [47:0] i_now_ms,
    input  logic [31:0] i_time_offset,
    input  logic [7:0]  i_listener_id,
    input  logic [31:0] i_cookie,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_fired_listener,
    output logic [31:0] o_fired_cookie,
    output logic [31:0] o_lateness_ms,
    output logic        o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_FIRE = 4'b0100,
        S_CLR  = 4'b1000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [NFIRE_W-1:0]     r_nfired;
    logic [NFIRE_W-1:0]     n_nfired;
    logic signed [DL_W-1:0] r_key;
    logic [7:0]             r_lis;
    logic [31:0]            r_ck;

    logic                   r_pend_v;
    logic                   n_pend_v;
    logic [7:0]             r_pend_lis;
    logic [31:0]            r_pend_ck;
    logic [31:0]            r_pend_late;

    logic                   r_ovalid;
    t_status                r_status;
    logic [7:0]             r_olis;
    logic [31:0]            r_ock;
    logic [31:0]            r_olate;
    logic                   r_olast;

    logic                   emit;
    t_status                e_status;
    logic [7:0]             e_lis;
    logic [31:0]            e_ck;
    logic [31:0]            e_late;
    logic                   e_last;
    logic                   load_pend;

    logic                   accept;
    logic                   out_free;
    logic                   due;
    logic                   emit_new;
    logic                   capped;
    logic [DL_W-1:0]        diff;
    logic [31:0]            late;
    logic signed [DL_W-1:0] in_dl;

    t_cell_ctl              cell_ctl;
    t_entry                 w_cell [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [QUEUE_DEPTH-1:0] w_occ;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign in_dl = $signed({2'b00, i_now_ms}) + $signed({{18{i_time_offset[31]}}, i_time_offset});

    assign due      = w_keep[0];
    assign emit_new = due && (w_cell[0].listener != 8'd0);
    assign capped   = emit_new && (r_nfired == NFIRE_W'(MAX_RESULTS));
    assign diff     = DL_W'(r_key - w_cell[0].deadline);
    assign late     = (|diff[DL_W-1:32]) ? 32'hFFFF_FFFF : diff[31:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_nfired  = r_nfired;
        n_pend_v  = r_pend_v;
        load_pend = 1'b0;
        emit      = 1'b0;
        e_status  = ST_SCHEDULED;
        e_lis     = 8'd0;
        e_ck      = 32'd0;
        e_late    = 32'd0;
        e_last    = 1'b1;
        cell_ctl.op        = OP_HOLD;
        cell_ctl.key       = r_key;
        cell_ctl.new_entry = '{deadline: r_key, listener: r_lis, cookie: r_ck};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_nfired = '0;
                    n_pend_v = 1'b0;
                    case (t_req'(i_req_type))
                        REQ_SCHEDULE: n_state = S_INS;
                        REQ_FIRE:     n_state = S_FIRE;
                        REQ_CLEAR:    n_state = S_CLR;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                        e_status = ST_DROPPED;
                    end else begin
                        e_status    = ST_SCHEDULED;
                        cell_ctl.op = OP_INSERT;
                        n_count     = r_count + 1'b1;
                    end
                end
            end
            S_FIRE: begin
                if (out_free) begin
                    if (due && !capped) begin
                        cell_ctl.op = OP_POP;
                        n_count     = r_count - 1'b1;
                        if (emit_new) begin
                            n_nfired  = r_nfired + 1'b1;
                            load_pend = 1'b1;
                            n_pend_v  = 1'b1;
                            if (r_pend_v) begin
                                emit     = 1'b1;
                                e_status = ST_FIRED;
                                e_lis    = r_pend_lis;
                                e_ck     = r_pend_ck;
                                e_late   = r_pend_late;
                                e_last   = 1'b0;
                            end
                        end
                    end else begin
                        emit     = 1'b1;
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                        if (r_pend_v) begin
                            e_status = ST_FIRED;
                            e_lis    = r_pend_lis;
                            e_ck     = r_pend_ck;
                            e_late   = r_pend_late;
                        end else begin
                            e_status = ST_NONE_DUE;
                        end
                    end
                end
            end
            S_CLR: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = ST_CLEARED;
                    n_count  = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_nfired <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_nfired <= n_nfired;
            r_pend_v <= n_pend_v;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= (i_req_type == REQ_SCHEDULE) ? in_dl : $signed({2'b00, i_now_ms});
            r_lis <= i_listener_id;
            r_ck  <= i_cookie;
        end
        if (load_pend) begin
            r_pend_lis  <= w_cell[0].listener;
            r_pend_ck   <= w_cell[0].cookie;
            r_pend_late <= late;
        end
        if (emit) begin
            r_status <= e_status;
            r_olis   <= e_lis;
            r_ock    <= e_ck;
            r_olate  <= e_late;
            r_olast  <= e_last;
        end
    end

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        assign w_occ[gi] = (CNT_W'(gi) < r_count);
        if (gi == 0) begin : g_head
            deq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_occ       (w_occ[gi]),
                .i_prev_keep (1'b1),
                .i_left      (w_cell[gi]),
                .i_right     (w_cell[(gi + 1) % QUEUE_DEPTH]),
                .o_entry     (w_cell[gi]),
                .o_keep      (w_keep[gi])
            );
        end else if (gi == QUEUE_DEPTH - 1) begin : g_tail
            deq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_occ       (w_occ[gi]),
                .i_prev_keep (w_keep[gi-1]),
                .i_left      (w_cell[gi-1]),
                .i_right     (w_cell[gi]),
                .o_entry     (w_cell[gi]),
                .o_keep      (w_keep[gi])
            );
        end else begin : g_mid
            deq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_occ       (w_occ[gi]),
                .i_prev_keep (w_keep[gi-1]),
                .i_left      (w_cell[gi-1]),
                .i_right     (w_cell[gi+1]),
                .o_entry     (w_cell[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_fired_listener = r_olis;
    assign o_fired_cookie   = r_ock;
    assign o_lateness_ms    = r_olate;
    assign o_last           = r_olast;

endmodule

[bench/deq_checker.sv]
`timescale 1ns / 100ps
// Checker for the deadline event queue: mirrors the timer queue and compares every result word.
module deq_checker
    import deq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [47:0] i_now_ms,
    input  logic [31:0] i_time_offset,
    input  logic [7:0]  i_listener_id,
    input  logic [31:0] i_cookie,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_fired_listener,
    input  logic [31:0] i_fired_cookie,
    input  logic [31:0] i_lateness_ms,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_status     status;
        logic [7:0]  listener;
        logic [31:0] cookie;
        logic [31:0] lateness;
        logic        last;
    } t_timer_result;

    logic signed [DL_W-1:0] mirror_deadline [QUEUE_DEPTH];
    logic [7:0]             mirror_listener [QUEUE_DEPTH];
    logic [31:0]            mirror_cookie   [QUEUE_DEPTH];
    int                     mirror_count;
    t_timer_result          awaited_results [$];
    int                     fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
        mirror_count = 0;
    end

    function automatic t_timer_result make_result(t_status status, logic [7:0] listener,
                                                  logic [31:0] cookie, logic [31:0] lateness,
                                                  logic last);
        t_timer_result r;
        r.status   = status;
        r.listener = listener;
        r.cookie   = cookie;
        r.lateness = lateness;
        r.last     = last;
        return r;
    endfunction

    task automatic queue_result(input t_timer_result r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic pop_earliest();
        for (int i = 0; i < mirror_count - 1; i++) begin
            mirror_deadline[i] = mirror_deadline[i + 1];
            mirror_listener[i] = mirror_listener[i + 1];
            mirror_cookie[i]   = mirror_cookie[i + 1];
        end
        mirror_count--;
    endtask

    task automatic predict_timer_results(input logic [1:0] req, input logic [47:0] now,
                                         input logic [31:0] offset, input logic [7:0] listener,
                                         input logic [31:0] cookie);
        logic signed [DL_W-1:0] now_s;
        logic signed [DL_W-1:0] deadline;
        logic signed [DL_W-1:0] diff;
        logic [31:0]            lateness;
        int                     pos;
        int                     fired;
        now_s = $signed({2'b00, now});
        case (req)
            REQ_SCHEDULE: begin
                if (mirror_count >= QUEUE_DEPTH) begin
                    queue_result(make_result(ST_DROPPED, 8'd0, 32'd0, 32'd0, 1'b1));
                end else begin
                    deadline = now_s + $signed({{(DL_W - 32){offset[31]}}, offset});
                    pos = 0;
                    while (pos < mirror_count && mirror_deadline[pos] <= deadline) pos++;
                    for (int i = mirror_count; i > pos; i--) begin
                        mirror_deadline[i] = mirror_deadline[i - 1];
                        mirror_listener[i] = mirror_listener[i - 1];
                        mirror_cookie[i]   = mirror_cookie[i - 1];
                    end
                    mirror_deadline[pos] = deadline;
                    mirror_listener[pos] = listener;
                    mirror_cookie[pos]   = cookie;
                    mirror_count++;
                    queue_result(make_result(ST_SCHEDULED, 8'd0, 32'd0, 32'd0, 1'b1));
                end
            end
            REQ_FIRE: begin
                fired = 0;
                while (mirror_count > 0 && mirror_deadline[0] <= now_s
                       && !(mirror_listener[0] != 8'd0 && fired >= MAX_RESULTS)) begin
                    if (mirror_listener[0] != 8'd0) begin
                        diff     = now_s - mirror_deadline[0];
                        lateness = (diff[DL_W-1:32] != '0) ? 32'hFFFF_FFFF : diff[31:0];
                        queue_result(make_result(ST_FIRED, mirror_listener[0],
                                                 mirror_cookie[0], lateness, 1'b0));
                        fired++;
                    end
                    pop_earliest();
                end
                if (fired == 0)
                    queue_result(make_result(ST_NONE_DUE, 8'd0, 32'd0, 32'd0, 1'b1));
                else
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
            REQ_CLEAR: begin
                mirror_count = 0;
                queue_result(make_result(ST_CLEARED, 8'd0, 32'd0, 32'd0, 1'b1));
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            mirror_count = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = make_result(t_status'(i_status), i_fired_listener, i_fired_cookie,
                                  i_lateness_ms, i_last);
                if (awaited_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected word status %0d listener %0d cookie %h late %h last %b",
                             $time, got.status, got.listener, got.cookie, got.lateness, got.last);
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        $display("%0t: expected status %0d listener %0d cookie %h late %h last %b",
                                 $time, want.status, want.listener, want.cookie, want.lateness,
                                 want.last);
                        $display("%0t:   actual status %0d listener %0d cookie %h late %h last %b",
                                 $time, got.status, got.listener, got.cookie, got.lateness,
                                 got.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_timer_results(i_req_type, i_now_ms, i_time_offset, i_listener_id,
                                      i_cookie);
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_total;
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the deadline event queue: clock, reset, stimulus, stalls and verdict.
module tb_top;
    import deq_pkg::*;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type       = 2'd0;
    logic [47:0] i_now_ms         = 48'd0;
    logic [31:0] i_time_offset    = 32'd0;
    logic [7:0]  i_listener_id    = 8'd0;
    logic [31:0] i_cookie         = 32'd0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_fired_listener;
    logic [31:0] o_fired_cookie;
    logic [31:0] o_lateness_ms;
    logic        o_last;

    int fail_count;
    int pending;
    int words_sent = 0;
    int tx_quiet   = 0;
    int rx_quiet   = 0;
    int rx_hold    = 0;
    int rx_draw;

    deadline_event_queue u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_now_ms         (i_now_ms),
        .i_time_offset    (i_time_offset),
        .i_listener_id    (i_listener_id),
        .i_cookie         (i_cookie),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_fired_listener (o_fired_listener),
        .o_fired_cookie   (o_fired_cookie),
        .o_lateness_ms    (o_lateness_ms),
        .o_last           (o_last)
    );

    deq_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_req_type       (i_req_type),
        .i_now_ms         (i_now_ms),
        .i_time_offset    (i_time_offset),
        .i_listener_id    (i_listener_id),
        .i_cookie         (i_cookie),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_status         (o_status),
        .i_fired_listener (o_fired_listener),
        .i_fired_cookie   (o_fired_cookie),
        .i_lateness_ms    (o_lateness_ms),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_hold <= 0;
        end else if (o_valid && !i_stall) begin
            rx_draw  = (rx_quiet > 0) ? 0 : $urandom_range(0, 12);
            rx_quiet = (rx_quiet > 0) ? rx_quiet - 1 : (($urandom_range(0, 19) == 0) ? 30 : 0);
            rx_hold <= rx_draw;
            i_stall <= (rx_draw != 0);
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= (rx_hold > 1);
        end
    end

    task automatic send_word(input t_req req, input logic [47:0] now, input logic [31:0] offset,
                             input logic [7:0] listener, input logic [31:0] cookie);
        int gap;
        if (tx_quiet > 0) begin
            gap = 0;
            tx_quiet--;
        end else begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 19) == 0) tx_quiet = 25;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_now_ms      <= now;
        i_time_offset <= offset;
        i_listener_id <= listener;
        i_cookie      <= cookie;
        do @(posedge i_clk); while (o_stall);
        if (req != REQ_UNUSED) words_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_listener();
        return ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    endfunction

    initial begin
        logic [47:0] tb_now;
        logic [47:0] fire_now;
        logic [31:0] offset;
        int          kind;
        int          burst;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, deadline extremes, listener 0 and equal deadlines
        send_word(REQ_FIRE, 48'd0, 32'd0, 8'd0, 32'd0);
        send_word(REQ_SCHEDULE, 48'd0, 32'h8000_0000, 8'd255, 32'hFFFF_FFFF);
        send_word(REQ_SCHEDULE, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 8'd1, 32'd0);
        send_word(REQ_SCHEDULE, 48'd0, 32'd0, 8'd0, 32'h5A5A_5A5A);
        send_word(REQ_SCHEDULE, 48'd0, 32'd0, 8'd7, 32'd1);
        send_word(REQ_SCHEDULE, 48'd0, 32'd0, 8'd8, 32'd2);
        send_word(REQ_FIRE, 48'hFFFF_FFFF_FFFF, 32'd0, 8'd0, 32'd0);
        drain_results();

        // fill to capacity, overflow, then drain with lateness at the saturation edge
        fire_now = 48'h1_0000_0000 + 48'd1000;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (i == 0)
                send_word(REQ_SCHEDULE, 48'd1001, 32'd0, pick_listener() | 8'd1, $urandom);
            else if (i == 1)
                send_word(REQ_SCHEDULE, 48'd1000, 32'd0, pick_listener() | 8'd1, $urandom);
            else
                send_word(REQ_SCHEDULE, fire_now, 32'd0 - 32'($urandom_range(0, 50)),
                          pick_listener(), $urandom);
        end
        send_word(REQ_SCHEDULE, fire_now, 32'd0, 8'd9, 32'hDEAD_0001);
        send_word(REQ_FIRE, fire_now, 32'd0, 8'd0, 32'd0);
        send_word(REQ_CLEAR, fire_now, 32'd0, 8'd0, 32'd0);
        send_word(REQ_SCHEDULE, 48'd10, 32'd5, 8'd0, 32'h1234_5678);
        send_word(REQ_FIRE, 48'd15, 32'd0, 8'd0, 32'd0);
        send_word(REQ_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);

        words_sent = 0;
        tb_now     = {16'($urandom_range(0, 32767)), 32'($urandom)};
        offset     = 32'd0;
        while (words_sent < 200) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 18)
                                                    : $urandom_range(1, 5);
                for (int k = 0; k < burst; k++) begin
                    case ($urandom_range(0, 9))
                        0, 1:    offset = offset;
                        2, 3:    offset = 32'd0 - 32'($urandom_range(0, 100));
                        4:       offset = $urandom;
                        default: offset = 32'($urandom_range(0, 200));
                    endcase
                    send_word(REQ_SCHEDULE, tb_now, offset, pick_listener(), $urandom);
                    if ($urandom_range(0, 2) == 0) tb_now += 48'($urandom_range(0, 5));
                end
                tb_now += 48'($urandom_range(0, 250));
                send_word(REQ_FIRE, tb_now, $urandom, pick_listener(), $urandom);
            end else if (kind < 75) begin
                send_word(REQ_CLEAR, tb_now, $urandom, pick_listener(), $urandom);
            end else if (kind < 80) begin
                drain_results();
                tb_now += 48'($urandom_range(0, 400));
                send_word(REQ_FIRE, tb_now, $urandom, pick_listener(), $urandom);
            end else if (kind < 90) begin
                send_word(t_req'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)},
                          $urandom, 8'($urandom), $urandom);
            end else begin
                tb_now += 48'($urandom_range(0, 1000));
                send_word(REQ_FIRE, tb_now, $urandom, pick_listener(), $urandom);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/deadline_event_queue.sv
bench/deq_checker.sv
bench/tb_top.sv
